// ----- rtl/sie_pkg.sv -----
package sie_pkg;

  // Default sizes of the register file and the data memory
  localparam int RegCountDef = 32;
  localparam int MemWordsDef = 2048;

  localparam int XLEN      = 32;
  localparam int RegIdxW   = 5;
  localparam int ShamtW    = 5;
  localparam int TargetW   = 28;
  localparam int MemAddrW  = 11;

  // Packed stream words, padded to whole bytes
  localparam int InTdataW  = 88;
  localparam int OutTdataW = 88;

  // jmp keeps these bits of the incremented PC
  localparam logic [XLEN-1:0] JMP_KEEP_MASK = 32'hF000_0000;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MUL   = 4'd2,
    OP_MOVI  = 4'd3,
    OP_JEQ   = 4'd4,
    OP_AND   = 4'd5,
    OP_XORI  = 4'd6,
    OP_JMP   = 4'd7,
    OP_LSL   = 4'd8,
    OP_LSR   = 4'd9,
    OP_LOAD  = 4'd10,
    OP_STORE = 4'd11
  } op_e;

  // One register write, pending or committed
  typedef struct packed {
    logic               en;
    logic [RegIdxW-1:0] idx;
    logic [XLEN-1:0]    data;
  } rf_wr_t;

endpackage

// ----- rtl/sie_ram.sv -----
module sie_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 32,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold the last read word while not enabled
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/sie_regfile.sv -----
module sie_regfile #(
  parameter int REG_COUNT = sie_pkg::RegCountDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [sie_pkg::RegIdxW-1:0]  rd_idx_a_i,
  input  logic [sie_pkg::RegIdxW-1:0]  rd_idx_b_i,
  input  sie_pkg::rf_wr_t              pend_i,
  input  logic                         commit_i,
  output logic [sie_pkg::XLEN-1:0]     opnd_a_o,
  output logic [sie_pkg::XLEN-1:0]     opnd_b_o
);

  localparam int RfAw = $clog2(REG_COUNT);

  logic [sie_pkg::RegIdxW-1:0] idx_a_q, idx_b_q;
  logic [REG_COUNT-1:0]        valid_q;
  sie_pkg::rf_wr_t             last_q;
  logic [sie_pkg::XLEN-1:0]    rdata_a, rdata_b;
  logic                        we;

  assign we = commit_i && pend_i.en;

  // Two copies, written together, give two read ports
  sie_ram #(.WIDTH(sie_pkg::XLEN), .DEPTH(REG_COUNT)) u_bank_a (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (pend_i.idx[RfAw-1:0]),
    .wdata_i (pend_i.data),
    .re_i    (rd_en_i),
    .raddr_i (rd_idx_a_i[RfAw-1:0]),
    .rdata_o (rdata_a)
  );

  sie_ram #(.WIDTH(sie_pkg::XLEN), .DEPTH(REG_COUNT)) u_bank_b (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (pend_i.idx[RfAw-1:0]),
    .wdata_i (pend_i.data),
    .re_i    (rd_en_i),
    .raddr_i (rd_idx_b_i[RfAw-1:0]),
    .rdata_o (rdata_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      last_q  <= '0;
    end else begin
      if (we) begin
        valid_q[pend_i.idx[RfAw-1:0]] <= 1'b1;
      end
      if (commit_i) begin
        last_q <= pend_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      idx_a_q <= rd_idx_a_i;
      idx_b_q <= rd_idx_b_i;
    end
  end

  // Pending write first, then the write that may have raced the read,
  // then the array; never-written entries read as zero.
  function automatic logic [sie_pkg::XLEN-1:0] pick(
    input logic [sie_pkg::RegIdxW-1:0] idx,
    input logic [sie_pkg::XLEN-1:0]    rdata,
    input sie_pkg::rf_wr_t             pend,
    input sie_pkg::rf_wr_t             last,
    input logic [REG_COUNT-1:0]        valid
  );
    logic [sie_pkg::XLEN-1:0] res;
    res = '0;
    if ({1'b0, idx} >= 6'(REG_COUNT)) begin
      res = '0;
    end else if (pend.en && pend.idx == idx) begin
      res = pend.data;
    end else if (last.en && last.idx == idx) begin
      res = last.data;
    end else if (valid[idx[RfAw-1:0]]) begin
      res = rdata;
    end
    return res;
  endfunction

  assign opnd_a_o = pick(idx_a_q, rdata_a, pend_i, last_q, valid_q);
  assign opnd_b_o = pick(idx_b_q, rdata_b, pend_i, last_q, valid_q);

endmodule

// ----- rtl/sie_datamem.sv -----
module sie_datamem #(
  parameter  int MEM_WORDS = sie_pkg::MemWordsDef,
  localparam int MemAw     = $clog2(MEM_WORDS)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     re_i,
  input  logic [MemAw-1:0]         raddr_i,
  input  logic                     we_i,
  input  logic [MemAw-1:0]         waddr_i,
  input  logic [sie_pkg::XLEN-1:0] wdata_i,
  output logic [sie_pkg::XLEN-1:0] rdata_o,
  output logic                     busy_o
);

  logic             clr_q;
  logic [MemAw-1:0] clr_addr_q;
  logic             ram_we;
  logic [MemAw-1:0] ram_waddr;
  logic [sie_pkg::XLEN-1:0] ram_wdata;

  // Sweep zeros through every word after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + MemAw'(1);
      if (clr_addr_q == MemAw'(MEM_WORDS - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  always_comb begin
    ram_we    = we_i;
    ram_waddr = waddr_i;
    ram_wdata = wdata_i;
    if (clr_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end
  end

  sie_ram #(.WIDTH(sie_pkg::XLEN), .DEPTH(MEM_WORDS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (re_i),
    .raddr_i (raddr_i),
    .rdata_o (rdata_o)
  );

  assign busy_o = clr_q;

endmodule

// ----- rtl/small_isa_execute_unit_top.sv -----
// Execute unit for a small twelve-opcode ISA. Each input word carries one
// decoded instruction; each output word reports the PC after it, whether a
// branch was taken, and any register or memory write. The unit runs a
// three-stage pipeline: the register file is read as the word is taken,
// operands are formed and the ALU, multiplier, branch logic and data memory
// access run in the second stage, and the third stage is the output
// register, from which register writes commit. One instruction is taken every
// cycle while the output side keeps up; a load feeding the very next
// instruction costs nothing, as results are forwarded from the output stage
// and from the last committed write. After reset the data memory is swept
// to zero, one word a cycle, and s_axis_tready stays low until the sweep is
// done. MEM_WORDS must be a power of two; addresses wrap by masking.
module small_isa_execute_unit_top #(
  parameter int REG_COUNT = sie_pkg::RegCountDef,
  parameter int MEM_WORDS = sie_pkg::MemWordsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // op[3:0], dest_reg[8:4], src_reg_a[13:9], src_reg_b[18:14],
  // shift_amount[23:19], immediate[55:24], jump_target[83:56], zero[87:84]
  input  logic [sie_pkg::InTdataW-1:0]     s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // pc_after[31:0], branch_taken[32], reg_written[33], written_reg[38:34],
  // written_value[70:39], mem_written[71], mem_address[82:72], zero[87:83]
  output logic [sie_pkg::OutTdataW-1:0]    m_axis_tdata
);

  localparam int MemAw = $clog2(MEM_WORDS);

  // ---------------------------------------------------------------
  // Input word unpacking
  // ---------------------------------------------------------------
  sie_pkg::op_e                   in_op;
  logic [sie_pkg::RegIdxW-1:0]    in_rd, in_ra, in_rb, in_idx_b;
  logic [sie_pkg::ShamtW-1:0]     in_sh;
  logic [sie_pkg::XLEN-1:0]       in_imm;
  logic [sie_pkg::TargetW-1:0]    in_tgt;

  assign in_op  = sie_pkg::op_e'(s_axis_tdata[3:0]);
  assign in_rd  = s_axis_tdata[8:4];
  assign in_ra  = s_axis_tdata[13:9];
  assign in_rb  = s_axis_tdata[18:14];
  assign in_sh  = s_axis_tdata[23:19];
  assign in_imm = s_axis_tdata[55:24];
  assign in_tgt = s_axis_tdata[83:56];

  // jeq compares dest_reg and store writes it out; neither needs src_reg_b
  assign in_idx_b = (in_op == sie_pkg::OP_JEQ || in_op == sie_pkg::OP_STORE) ? in_rd : in_rb;

  // ---------------------------------------------------------------
  // Pipeline control
  // ---------------------------------------------------------------
  logic s2_valid_q, s3_valid_q;
  logic accept, adv3, s2_fire, mem_busy;

  assign adv3          = !s3_valid_q || m_axis_tready;
  assign s2_fire       = s2_valid_q && adv3;
  assign s_axis_tready = !mem_busy && (!s2_valid_q || adv3);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s2_valid_q <= 1'b1;
      end else if (adv3) begin
        s2_valid_q <= 1'b0;
      end
      if (adv3) begin
        s3_valid_q <= s2_valid_q;
      end
    end
  end

  // ---------------------------------------------------------------
  // Stage 2 payload: everything except the source register indices, which the
  // register file keeps beside its read data
  // ---------------------------------------------------------------
  sie_pkg::op_e                   s2_op_q;
  logic [sie_pkg::RegIdxW-1:0]    s2_rd_q;
  logic [sie_pkg::ShamtW-1:0]     s2_sh_q;
  logic [sie_pkg::XLEN-1:0]       s2_imm_q;
  logic [sie_pkg::TargetW-1:0]    s2_tgt_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s2_op_q  <= in_op;
      s2_rd_q  <= in_rd;
      s2_sh_q  <= in_sh;
      s2_imm_q <= in_imm;
      s2_tgt_q <= in_tgt;
    end
  end

  // ---------------------------------------------------------------
  // Register file with forwarding
  // ---------------------------------------------------------------
  sie_pkg::rf_wr_t          pend;
  logic [sie_pkg::XLEN-1:0] opnd_a, opnd_b;

  sie_regfile #(.REG_COUNT(REG_COUNT)) u_regfile (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_idx_a_i (in_ra),
    .rd_idx_b_i (in_idx_b),
    .pend_i     (pend),
    .commit_i   (s3_valid_q && m_axis_tready),
    .opnd_a_o   (opnd_a),
    .opnd_b_o   (opnd_b)
  );

  // ---------------------------------------------------------------
  // Stage 2 execute
  // ---------------------------------------------------------------
  logic [sie_pkg::XLEN-1:0] pc_q, pc_inc, pc_d;
  logic [sie_pkg::XLEN-1:0] addr_sum, addr_m, ex_val;
  logic                     ex_taken, ex_wr, ex_load, ex_memw, ex_use_addr, rd_ok;

  assign rd_ok    = {1'b0, s2_rd_q} < 6'(REG_COUNT);
  assign addr_sum = opnd_a + s2_imm_q;
  assign addr_m   = addr_sum & 32'(MEM_WORDS - 1);
  assign pc_inc   = pc_q + 32'd1;

  always_comb begin
    pc_d        = pc_inc;
    ex_taken    = 1'b0;
    ex_wr       = 1'b0;
    ex_load     = 1'b0;
    ex_memw     = 1'b0;
    ex_use_addr = 1'b0;
    ex_val      = '0;
    case (s2_op_q)
      sie_pkg::OP_ADD: begin
        ex_val = opnd_a + opnd_b;
        ex_wr  = 1'b1;
      end
      sie_pkg::OP_SUB: begin
        ex_val = opnd_a - opnd_b;
        ex_wr  = 1'b1;
      end
      sie_pkg::OP_MUL: begin
        ex_val = opnd_a * opnd_b;
        ex_wr  = 1'b1;
      end
      sie_pkg::OP_MOVI: begin
        ex_val = s2_imm_q;
        ex_wr  = 1'b1;
      end
      sie_pkg::OP_JEQ: begin
        if (opnd_b == opnd_a) begin
          pc_d     = pc_inc + 32'd1 + s2_imm_q;
          ex_taken = 1'b1;
        end
      end
      sie_pkg::OP_AND: begin
        ex_val = opnd_a & opnd_b;
        ex_wr  = 1'b1;
      end
      sie_pkg::OP_XORI: begin
        ex_val = opnd_a ^ s2_imm_q;
        ex_wr  = 1'b1;
      end
      sie_pkg::OP_JMP: begin
        pc_d     = (pc_inc & sie_pkg::JMP_KEEP_MASK) | {4'b0000, s2_tgt_q};
        ex_taken = 1'b1;
      end
      sie_pkg::OP_LSL: begin
        ex_val = opnd_a << s2_sh_q;
        ex_wr  = 1'b1;
      end
      sie_pkg::OP_LSR: begin
        ex_val = opnd_a >> s2_sh_q;
        ex_wr  = 1'b1;
      end
      sie_pkg::OP_LOAD: begin
        ex_wr       = 1'b1;
        ex_load     = 1'b1;
        ex_use_addr = 1'b1;
      end
      sie_pkg::OP_STORE: begin
        ex_val      = opnd_b;
        ex_memw     = 1'b1;
        ex_use_addr = 1'b1;
      end
      default: begin
      end
    endcase
    // drop writes to registers that do not exist
    if (ex_wr && !rd_ok) begin
      ex_wr   = 1'b0;
      ex_load = 1'b0;
      ex_val  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else if (s2_fire) begin
      pc_q <= pc_d;
    end
  end

  // ---------------------------------------------------------------
  // Data memory: loads read and stores write as stage 2 advances
  // ---------------------------------------------------------------
  logic [sie_pkg::XLEN-1:0] mem_rdata;

  sie_datamem #(.MEM_WORDS(MEM_WORDS)) u_datamem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (s2_fire && s2_op_q == sie_pkg::OP_LOAD),
    .raddr_i (addr_m[MemAw-1:0]),
    .we_i    (s2_fire && ex_memw),
    .waddr_i (addr_m[MemAw-1:0]),
    .wdata_i (opnd_b),
    .rdata_o (mem_rdata),
    .busy_o  (mem_busy)
  );

  // ---------------------------------------------------------------
  // Stage 3: output register
  // ---------------------------------------------------------------
  logic [sie_pkg::XLEN-1:0]     s3_pc_q, s3_val_q, s3_wval;
  logic                         s3_taken_q, s3_wr_q, s3_load_q, s3_memw_q;
  logic [sie_pkg::RegIdxW-1:0]  s3_wreg_q;
  logic [sie_pkg::MemAddrW-1:0] s3_addr_q;

  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      s3_pc_q    <= pc_d;
      s3_taken_q <= ex_taken;
      s3_wr_q    <= ex_wr;
      s3_wreg_q  <= ex_wr ? s2_rd_q : '0;
      s3_val_q   <= ex_val;
      s3_load_q  <= ex_load;
      s3_memw_q  <= ex_memw;
      s3_addr_q  <= ex_use_addr ? addr_m[sie_pkg::MemAddrW-1:0] : '0;
    end
  end

  // load data comes straight from the memory's read register
  assign s3_wval = s3_load_q ? mem_rdata : s3_val_q;

  assign pend.en   = s3_valid_q && s3_wr_q;
  assign pend.idx  = s3_wreg_q;
  assign pend.data = s3_wval;

  assign m_axis_tvalid = s3_valid_q;
  assign m_axis_tdata  = {5'b00000, s3_addr_q, s3_memw_q, s3_wval, s3_wreg_q,
                          s3_wr_q, s3_taken_q, s3_pc_q};

  // ---------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------
  a_no_accept_while_clearing : assert property (
    @(posedge clk_i) disable iff (!rst_ni) mem_busy |-> !s_axis_tready
  ) else $error("instruction taken during data memory clear");

  a_one_write_kind : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(s3_wr_q && s3_memw_q)
  ) else $error("register and memory written by one instruction");

  a_pc_moves_on_issue : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !s2_fire |=> $stable(pc_q)
  ) else $error("PC changed without an instruction advancing");

  a_idle_output_after_clear : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    mem_busy |-> !s2_valid_q && !s3_valid_q
  ) else $error("pipeline occupied during data memory clear");

endmodule
